### rtl/sorted_table_binary_search_core_macros.svh
// Assertion macros used by the checker file of the sorted table search core.
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/stbs_pkg.sv
// Shared types and constants of the sorted table search core.
package stbs_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int INDEX_W      = 6;
    localparam int IN_TDATA_W   = 32;
    localparam int IN_TUSER_W   = 1;
    localparam int OUT_TDATA_W  = 8;

    typedef enum logic {
        KIND_APPEND = 1'b0,
        KIND_SEARCH = 1'b1
    } t_kind;

    // Packed with found in the lowest bit, so it maps straight onto the output tdata.
    typedef struct packed {
        logic               full_res;
        logic [INDEX_W-1:0] index;
        logic               found;
    } t_result;

endpackage

### rtl/sorted_table_binary_search_core.sv
// Top level of the sorted table search core: stream ports, output register, table RAM.
//
//   channel  direction  tdata                          tuser
//   s_axis   in         value[31:0]                    kind[0]
//   m_axis   out        found[0] index[6:1] full[7]    -
//
// An append passes through the sequencer's result register and S_DONE into the output register.
// A search makes at most floor(log2(CAPACITY)) + 1 probes before its result moves from the
// sequencer into the output register; the single read port of the table RAM sets the pace.
// Reset clears only the fill count and control state; the table needs no clearing pass.
// The input is not ready while an item is in progress; a finished result waits in the
// sequencer until the output register is free, while one earlier result sits there.
module sorted_table_binary_search_core #(
    parameter int CAPACITY = stbs_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [stbs_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,  // value[31:0]
    input  logic [stbs_pkg::IN_TUSER_W-1:0]      i_s_axis_tuser,  // kind[0]
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [stbs_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata   // found[0] index[6:1] full_res[7]
);

    localparam int AW = $clog2(CAPACITY);

    logic                          start;
    logic                          out_free;
    logic                          seq_ready;
    logic                          seq_done;
    stbs_pkg::t_result             seq_res;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [stbs_pkg::VALUE_W-1:0]  ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [stbs_pkg::VALUE_W-1:0]  ram_rdata;

    logic                          r_out_valid;
    stbs_pkg::t_result             r_out_res;

    assign start    = i_s_axis_tvalid && seq_ready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    stbs_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_kind     (stbs_pkg::t_kind'(i_s_axis_tuser[0])),
        .i_value    (i_s_axis_tdata),
        .i_out_free (out_free),
        .i_rd_data  (ram_rdata),
        .o_ready    (seq_ready),
        .o_done     (seq_done),
        .o_res      (seq_res),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata),
        .o_raddr    (ram_raddr)
    );

    stbs_ram #(
        .WIDTH (stbs_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (seq_done) begin
                r_out_valid <= 1'b1;
                r_out_res   <= seq_res;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_axis_tready = seq_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_res;

endmodule

### rtl/stbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module stbs_ram #(
    parameter int WIDTH = stbs_pkg::VALUE_W,
    parameter int DEPTH = stbs_pkg::CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/stbs_seq.sv
// Sequencer of the search core: appends, fill count and the iterative probe loop.
module stbs_seq #(
    parameter int CAPACITY = stbs_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  stbs_pkg::t_kind                    i_kind,
    input  logic [stbs_pkg::VALUE_W-1:0]       i_value,
    input  logic                               i_out_free,
    input  logic [stbs_pkg::VALUE_W-1:0]       i_rd_data,
    output logic                               o_ready,
    output logic                               o_done,
    output stbs_pkg::t_result                  o_res,
    output logic                               o_we,
    output logic [$clog2(CAPACITY)-1:0]        o_waddr,
    output logic [stbs_pkg::VALUE_W-1:0]       o_wdata,
    output logic [$clog2(CAPACITY)-1:0]        o_raddr
);

    localparam int AW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int IndexW = stbs_pkg::INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [CW-1:0]                 r_fill;
    logic [CW-1:0]                 r_lo;
    logic [CW-1:0]                 r_hi;
    logic [AW-1:0]                 r_mid;
    logic [stbs_pkg::VALUE_W-1:0]  r_key;
    stbs_pkg::t_result             r_res;

    logic          table_full;
    logic          probe_eq;
    logic          probe_lt;
    logic [CW-1:0] n_lo;
    logic [CW-1:0] n_hi;
    logic [CW-1:0] n_span;
    logic [CW-1:0] n_mid_wide;
    logic [AW-1:0] start_mid;
    logic [AW-1:0] probe_mid;

    assign table_full = (r_fill >= CW'(CAPACITY));

    // The entry read last cycle at r_mid is on the RAM output now.
    assign probe_eq = (i_rd_data == r_key);
    assign probe_lt = ($signed(i_rd_data) < $signed(r_key));

    // A span of one probes lo itself, which is the direct final compare.
    always_comb begin
        if (probe_lt) begin
            n_lo = CW'(r_mid) + CW'(1);
            n_hi = r_hi;
        end else begin
            n_lo = r_lo;
            n_hi = CW'(r_mid);
        end
        n_span     = n_hi - n_lo;
        n_mid_wide = n_lo + (n_span >> 1);
    end

    assign probe_mid = AW'(n_mid_wide);
    assign start_mid = AW'(r_fill >> 1);

    assign o_raddr = (r_state == S_IDLE) ? start_mid : probe_mid;
    assign o_we    = i_start && (i_kind == stbs_pkg::KIND_APPEND) && !table_full;
    assign o_waddr = AW'(r_fill);
    assign o_wdata = i_value;

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE) && i_out_free;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_kind == stbs_pkg::KIND_APPEND) begin
                            if (table_full) begin
                                r_res <= '{full_res: 1'b1, index: '0, found: 1'b0};
                            end else begin
                                r_res  <= '{full_res: 1'b0, index: IndexW'(r_fill),
                                           found: 1'b0};
                                r_fill <= r_fill + CW'(1);
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_key <= i_value;
                            r_lo  <= '0;
                            r_hi  <= r_fill;
                            r_mid <= start_mid;
                            if (r_fill == '0) begin
                                r_res   <= '{full_res: 1'b0, index: '0, found: 1'b0};
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_PROBE;
                            end
                        end
                    end
                end
                S_PROBE: begin
                    if (probe_eq) begin
                        r_res   <= '{full_res: 1'b0, index: IndexW'(r_mid), found: 1'b1};
                        r_state <= S_DONE;
                    end else if (n_span == '0) begin
                        r_res   <= '{full_res: 1'b0, index: '0, found: 1'b0};
                        r_state <= S_DONE;
                    end else begin
                        r_lo  <= n_lo;
                        r_hi  <= n_hi;
                        r_mid <= probe_mid;
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/stbs_checker.sv
// Port-level checker of the sorted table search core, bound to the top level.
`include "sorted_table_binary_search_core_macros.svh"

module stbs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic [stbs_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input logic [stbs_pkg::IN_TUSER_W-1:0]   i_s_axis_tuser,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [stbs_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    stbs_pkg::t_result res;
    logic              in_accept;

    assign res       = o_m_axis_tdata;
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    // A stalled result must stay put until it is taken.
    `STBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed or vanished")

    // A dropped append is never a match and reports no position.
    `STBS_ASSERT_NOW(a_full_clean, i_clk, i_rst_n, o_m_axis_tvalid && res.full_res, !res.found && (res.index == '0), "full flag with found or nonzero index")

    // Every accepted item keeps the sequencer busy, so the input drops ready after it.
    `STBS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, !o_s_axis_tready, "input ready right after an accepted item")

    // An offered item carries fully known kind and value bits.
    `STBS_ASSERT_NOW(a_in_known, i_clk, i_rst_n, i_s_axis_tvalid, !$isunknown({i_s_axis_tuser, i_s_axis_tdata}), "offered item has unknown bits")

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (.*);
